// ----- src/masked_key_energy_merger_core_macros.svh -----
// Assertion macros used by the port-level checker.
// No dependencies.
`ifndef MASKED_KEY_ENERGY_MERGER_CORE_MACROS_SVH
`define MASKED_KEY_ENERGY_MERGER_CORE_MACROS_SVH
// Assert an implication, disabled during reset.
`define MKEM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
// Assert a next-cycle implication, disabled during reset.
`define MKEM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`endif

// ----- src/mkem_pkg.sv -----
// Package for the masked key energy merger: widths, types, constants.
// No dependencies.
`timescale 1ns / 1ps
package mkem_pkg;
  localparam int TableDepth = 64;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);
  localparam int SumW = 40;
  localparam int DropW = 16;
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
  localparam logic [DropW-1:0] DropMax = {DropW{1'b1}};
  localparam int QDepth = 2;

  localparam logic KindHit = 1'b0;
  localparam logic KindEnd = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [63:0] cell_id;
    logic [31:0] energy;
  } cmd_t;
endpackage

// ----- src/mkem_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module mkem_ram #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- src/mkem_front.sv -----
// Front end: input handshake and a short command queue.
// Depends on mkem_pkg.
`timescale 1ns / 1ps
module mkem_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mkem_pkg::cmd_t    in_cmd,
  output logic              q_valid,
  input  logic              q_pop,
  output mkem_pkg::cmd_t    q_cmd
);
  import mkem_pkg::*;
  localparam int PW = $clog2(QDepth);
  cmd_t mem [QDepth];
  logic [PW-1:0] wptr, rptr;
  logic [PW:0] count;
  logic push;

  assign in_ready = (count != PW'(0) + (PW+1)'(QDepth));
  assign push = in_valid && in_ready;
  assign q_valid = (count != '0);
  assign q_cmd = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_cmd;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (q_pop) rptr <= rptr + 1'b1;
      count <= count + (PW+1)'(push) - (PW+1)'(q_pop);
    end
  end
endmodule

// ----- src/mkem_back.sv -----
// Back end: key search over the table, read-modify-write merge, event emit.
// Depends on mkem_pkg and mkem_ram.
`timescale 1ns / 1ps
module mkem_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_pop,
  input  mkem_pkg::cmd_t    q_cmd,
  input  logic [63:0]       keep_mask,
  input  logic [63:0]       ref_bits,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [5:0]        group_index,
  output logic [63:0]       first_cell_id,
  output logic [63:0]       group_key,
  output logic [63:0]       ref_cell_id,
  output logic [39:0]       energy_sum,
  output logic              sum_saturated,
  output logic [15:0]       dropped_hits,
  output logic              empty_event,
  output logic              last
);
  import mkem_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_CHECK = 6'b000100,
    S_EMIT  = 6'b001000,
    S_ERD   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;
  logic [CntW-1:0] group_count, scan;
  logic [DropW-1:0] drop_count;
  logic [63:0] key;

  // key search: keys kept in a RAM, compared one entry per cycle; the read
  // runs one entry ahead so the entry under test is always on key_r
  logic [63:0] key_r;

  logic ram_we;
  logic [IdxW-1:0] waddr, raddr;
  logic [63:0] fid_w, fid_r;
  logic [SumW:0] sum_w, sum_r;
  logic [SumW:0] add;

  mkem_ram #(.Width(64), .Depth(TableDepth)) u_key (
    .clk, .we(ram_we && state == S_SCAN), .waddr, .wdata(key), .raddr, .rdata(key_r));
  mkem_ram #(.Width(64), .Depth(TableDepth)) u_fid (
    .clk, .we(ram_we && state == S_SCAN), .waddr, .wdata(fid_w), .raddr, .rdata(fid_r));
  mkem_ram #(.Width(SumW+1), .Depth(TableDepth)) u_sum (
    .clk, .we(ram_we), .waddr, .wdata(sum_w), .raddr, .rdata(sum_r));

  logic hit_now, miss_now;
  assign hit_now  = state == S_SCAN && scan < group_count && key_r == key;
  assign miss_now = state == S_SCAN && scan >= group_count;

  // entry 0 is fetched while idle; advance the fetch while the search moves on
  always_comb begin
    raddr = scan[IdxW-1:0];
    if (state == S_IDLE) raddr = '0;
    else if (state == S_SCAN && !hit_now && !miss_now) raddr = scan[IdxW-1:0] + 1'b1;
  end

  assign fid_w = q_cmd.cell_id;
  assign add = {1'b0, sum_r[SumW-1:0]} + (SumW+1)'(q_cmd.energy);

  always_comb begin
    ram_we = 1'b0;
    waddr = group_count[IdxW-1:0];
    sum_w = {1'b0, SumW'(q_cmd.energy)};
    if (miss_now && group_count != CntW'(TableDepth)) begin
      ram_we = 1'b1;
    end else if (state == S_CHECK) begin
      ram_we = 1'b1;
      waddr = scan[IdxW-1:0];
      if (add[SumW-1:0] == SumMax || add[SumW]) sum_w = {1'b1, SumMax};
      else sum_w = {sum_r[SumW], add[SumW-1:0]};
    end
  end

  // a hit stays at the queue head until its sum is written back
  assign q_pop = miss_now || (state == S_CHECK) ||
                 (state == S_EMIT && group_count == '0 && !out_valid) ||
                 (state == S_OUT && !out_valid && scan == group_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      group_count <= '0;
      drop_count <= '0;
      scan <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          scan <= '0;
          key <= q_cmd.cell_id & keep_mask;
          if (q_valid) state <= (q_cmd.kind == KindEnd) ? S_EMIT : S_SCAN;
        end
        S_SCAN: begin
          // hold the hit entry: registered read of its sum arrives next cycle
          if (hit_now) state <= S_CHECK;
          else if (miss_now) begin
            if (group_count != CntW'(TableDepth)) group_count <= group_count + 1'b1;
            else if (drop_count != DropMax) drop_count <= drop_count + 1'b1;
            state <= S_IDLE;
          end else scan <= scan + 1'b1;
        end
        S_CHECK: state <= S_IDLE;
        S_EMIT: begin
          if (group_count == '0) begin
            if (!out_valid) begin
              out_valid <= 1'b1;
              group_index <= '0;
              first_cell_id <= '0;
              group_key <= '0;
              ref_cell_id <= '0;
              energy_sum <= '0;
              sum_saturated <= 1'b0;
              dropped_hits <= '0;
              empty_event <= 1'b1;
              last <= 1'b1;
              drop_count <= '0;
              state <= S_IDLE;
            end
          end else state <= S_ERD;
        end
        S_ERD: state <= S_OUT;
        S_OUT: begin
          if (!out_valid) begin
            if (scan == group_count) begin
              group_count <= '0;
              drop_count <= '0;
              state <= S_IDLE;
            end else begin
              out_valid <= 1'b1;
              group_index <= 6'(scan);
              first_cell_id <= fid_r;
              group_key <= key_r;
              ref_cell_id <= key_r | ref_bits;
              energy_sum <= sum_r[SumW-1:0];
              sum_saturated <= sum_r[SumW];
              dropped_hits <= drop_count;
              empty_event <= 1'b0;
              last <= (scan + 1'b1 == group_count);
              scan <= scan + 1'b1;
              state <= (scan + 1'b1 == group_count) ? S_OUT : S_ERD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- src/masked_key_energy_merger_core.sv -----
// Top level of the masked key energy merger.
// Depends on mkem_pkg, mkem_front and mkem_back.
`timescale 1ns / 1ps
// Groups the hits of one event by cell_id AND keep_mask and sums energies
// (40-bit, saturating) in a table of 64 groups kept in creation order. A hit
// with kind 0 searches the table until its key is found or found new; the
// search compares one stored key per cycle. A kind 1 item emits one
// transfer per group, or one empty-event transfer, then clears the table.
// The first group transfer waits for its registered RAM read; after that a
// new transfer is raised only once the previous one is taken and its RAM
// read is back. A two-entry queue in front takes items while the back end
// works. Hits beyond a full table are dropped and counted. The table needs
// no clearing pass.
module masked_key_energy_merger_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [63:0] cell_id,
  input  logic [31:0] energy,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  group_index,
  output logic [63:0] first_cell_id,
  output logic [63:0] group_key,
  output logic [63:0] ref_cell_id,
  output logic [39:0] energy_sum,
  output logic        sum_saturated,
  output logic [15:0] dropped_hits,
  output logic        empty_event,
  output logic        last
);
  import mkem_pkg::*;

  localparam logic RegKeepMask = 1'b0;
  localparam logic RegRefBits  = 1'b1;

  logic [63:0] keep_mask, ref_bits;
  cmd_t in_cmd, q_cmd;
  logic q_valid, q_pop;

  // configuration registers: the user must write them only while idle; the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_mask <= '1;
      ref_bits <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegKeepMask: keep_mask <= cfg_data;
        RegRefBits:  ref_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_cmd = '{kind: kind, cell_id: cell_id, energy: energy};

  mkem_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_cmd, .q_valid, .q_pop, .q_cmd);

  mkem_back u_back (
    .clk, .rst, .q_valid, .q_pop, .q_cmd, .keep_mask, .ref_bits,
    .out_valid, .out_ready, .group_index, .first_cell_id, .group_key,
    .ref_cell_id, .energy_sum, .sum_saturated, .dropped_hits, .empty_event,
    .last);
endmodule

// ----- src/mkem_checker.sv -----
// Port-level checker for the merger, bound to the top level.
// Depends on masked_key_energy_merger_core_macros.svh.
`timescale 1ns / 1ps
`include "masked_key_energy_merger_core_macros.svh"
module mkem_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] group_key,
  input logic [63:0] ref_cell_id,
  input logic [39:0] energy_sum,
  input logic        sum_saturated,
  input logic        empty_event,
  input logic        last,
  input logic [5:0]  group_index
);
  `MKEM_ASSERT_IMP(a_empty_last, out_valid && empty_event, last && group_index == 6'd0)
  `MKEM_ASSERT_IMP(a_sat_max, out_valid && sum_saturated, energy_sum == {40{1'b1}})
  `MKEM_ASSERT_IMP(a_ref_cov, out_valid && !empty_event, (ref_cell_id & group_key) == group_key)
  `MKEM_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(energy_sum))
endmodule

bind masked_key_energy_merger_core mkem_checker u_mkem_checker (
  .clk, .rst, .out_valid, .out_ready, .group_key, .ref_cell_id, .energy_sum,
  .sum_saturated, .empty_event, .last, .group_index);

// ----- tb/tb_masked_key_energy_merger_core.sv -----
// Self-checking testbench for the masked key energy merger core.
// Depends on mkem_pkg and masked_key_energy_merger_core; predicts groups per event.
`timescale 1ns / 1ps
module tb_masked_key_energy_merger_core;
  import mkem_pkg::*;

  localparam logic CfgKeepMask = 1'b0;
  localparam logic CfgRefBits  = 1'b1;
  localparam int   Depth       = 64;
  localparam int   DirRows     = 22;

  typedef struct packed {
    logic [5:0]  group_index;
    logic [63:0] first_cell_id;
    logic [63:0] group_key;
    logic [63:0] ref_cell_id;
    logic [39:0] energy_sum;
    logic        sum_saturated;
    logic [15:0] dropped_hits;
    logic        empty_event;
    logic        last;
  } group_rec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        kind = KindHit;
  logic [63:0] cell_id = '0;
  logic [31:0] energy = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  wire group_rec_t got;
  int          errors = 0;

  // Predictor state: own copy of the table and the registers.
  logic [63:0] keep_mask_m, ref_bits_m;
  logic [63:0] key_tab [Depth];
  logic [63:0] first_tab [Depth];
  logic [39:0] sum_tab [Depth];
  logic        sat_tab [Depth];
  int          groups_open;
  logic [15:0] drops_open;
  group_rec_t  pending_groups[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  masked_key_energy_merger_core dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_ready,
    .kind, .cell_id, .energy, .out_valid, .out_ready,
    .group_index(got.group_index), .first_cell_id(got.first_cell_id),
    .group_key(got.group_key), .ref_cell_id(got.ref_cell_id),
    .energy_sum(got.energy_sum), .sum_saturated(got.sum_saturated),
    .dropped_hits(got.dropped_hits), .empty_event(got.empty_event),
    .last(got.last)
  );

  // Merge one hit or flush the event into the expected-group queue.
  function automatic void merge_or_flush(logic k, logic [63:0] id, logic [31:0] e);
    logic [63:0] key;
    logic [40:0] s;
    group_rec_t r;
    key = id & keep_mask_m;
    if (k == KindHit) begin
      for (int i = 0; i < groups_open; i++) begin
        if (key_tab[i] == key) begin
          s = {1'b0, sum_tab[i]} + e;
          if (s >= {1'b0, SumMax}) begin
            s = {1'b0, SumMax};
            sat_tab[i] = 1'b1;
          end
          sum_tab[i] = s[39:0];
          return;
        end
      end
      if (groups_open < Depth) begin
        key_tab[groups_open] = key;
        first_tab[groups_open] = id;
        sum_tab[groups_open] = {8'd0, e};
        sat_tab[groups_open] = 1'b0;
        groups_open++;
      end else if (drops_open != DropMax) begin
        drops_open++;
      end
    end else begin
      if (groups_open == 0) begin
        r = '0;
        r.empty_event = 1'b1;
        r.last = 1'b1;
        pending_groups = {pending_groups, r};
      end
      for (int i = 0; i < groups_open; i++) begin
        r.group_index = i[5:0];
        r.first_cell_id = first_tab[i];
        r.group_key = key_tab[i];
        r.ref_cell_id = key_tab[i] | ref_bits_m;
        r.energy_sum = sum_tab[i];
        r.sum_saturated = sat_tab[i];
        r.dropped_hits = drops_open;
        r.empty_event = 1'b0;
        r.last = (i == groups_open - 1);
        pending_groups = {pending_groups, r};
      end
      groups_open = 0;
      drops_open = '0;
    end
  endfunction

  task automatic write_reg(logic idx, logic [63:0] val);
    // Let any trailing hit work drain before touching the registers.
    repeat (Depth + 8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgKeepMask) keep_mask_m = val;
    else ref_bits_m = val;
  endtask

  // Send one transfer; valid drops only when a gap follows.
  task automatic send_item(logic k, logic [63:0] id, logic [31:0] e);
    int gap;
    gap = $urandom_range(0, 14);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    cell_id <= id;
    energy <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    merge_or_flush(k, id, e);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_groups.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls per transfer, compare against oldest expectation.
  initial begin
    group_rec_t w;
    int stall;
    forever begin
      stall = $urandom_range(0, 14);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (pending_groups.size() == 0) begin
        $error("unexpected transfer");
        errors++;
      end else begin
        w = pending_groups.pop_front();
        if (got.group_index !== w.group_index) begin
          $error("group_index exp %0d got %0d", w.group_index, got.group_index); errors++;
        end
        if (got.first_cell_id !== w.first_cell_id) begin
          $error("first_cell_id exp %h got %h", w.first_cell_id, got.first_cell_id); errors++;
        end
        if (got.group_key !== w.group_key) begin
          $error("group_key exp %h got %h", w.group_key, got.group_key); errors++;
        end
        if (got.ref_cell_id !== w.ref_cell_id) begin
          $error("ref_cell_id exp %h got %h", w.ref_cell_id, got.ref_cell_id); errors++;
        end
        if (got.energy_sum !== w.energy_sum) begin
          $error("energy_sum exp %h got %h", w.energy_sum, got.energy_sum); errors++;
        end
        if (got.sum_saturated !== w.sum_saturated) begin
          $error("sum_saturated exp %b got %b", w.sum_saturated, got.sum_saturated); errors++;
        end
        if (got.dropped_hits !== w.dropped_hits) begin
          $error("dropped_hits exp %0d got %0d", w.dropped_hits, got.dropped_hits); errors++;
        end
        if (got.empty_event !== w.empty_event) begin
          $error("empty_event exp %b got %b", w.empty_event, got.empty_event); errors++;
        end
        if (got.last !== w.last) begin
          $error("last exp %b got %b", w.last, got.last); errors++;
        end
      end
    end
  end

  // Directed rows: extremes, large sums, same key merging, empty event.
  logic        dir_kind [DirRows];
  logic [63:0] dir_id   [DirRows];
  logic [31:0] dir_e    [DirRows];
  initial begin
    dir_kind = '{KindEnd, KindHit, KindHit, KindHit, KindEnd,
                 KindHit, KindHit, KindHit, KindHit, KindHit, KindHit, KindHit,
                 KindHit, KindHit, KindHit, KindHit, KindHit, KindHit, KindHit,
                 KindHit, KindHit, KindEnd};
    dir_id   = '{64'd0, 64'd0, '1, 64'd0, 64'd0,
                 64'h5, 64'h5, 64'h5, 64'h5, 64'h5, 64'h5, 64'h5,
                 64'h5, 64'h5, 64'h5, 64'h5, 64'h5, 64'h5, 64'h5,
                 64'h5, 64'h5, 64'd0};
    dir_e    = '{32'd0, 32'd0, '1, 32'd1, 32'd0,
                 '1, '1, '1, '1, '1, '1, '1,
                 '1, '1, '1, '1, '1, '1, '1,
                 '1, '1, 32'd0};
  end

  initial begin
    logic [63:0] base, masks [4];
    int ev_hits, pool;
    keep_mask_m = '1;
    ref_bits_m = '0;
    groups_open = 0;
    drops_open = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Empty event after reset: one marker with everything else zero.
    send_item(KindEnd, '0, '0);
    wait_drained();
    if (!(got.empty_event === 1'b1 && got.last === 1'b1 && got.energy_sum === '0)) begin
      $error("empty_event marker after reset wrong"); errors++;
    end
    for (int r = 1; r < DirRows; r++) send_item(dir_kind[r], dir_id[r], dir_e[r]);
    wait_drained();
    // 16 max hits on key 5 sum to 2^36-16, still short of the 40-bit limit.
    if (got.energy_sum !== 40'h0F_FFFF_FFF0 || got.sum_saturated !== 1'b0) begin
      $error("energy_sum exp %h got %h", 40'h0F_FFFF_FFF0, got.energy_sum); errors++;
    end
    // Full table: 64 distinct keys plus drops, with ref bits set.
    write_reg(CfgRefBits, '1);
    for (int i = 0; i < Depth + 5; i++) send_item(KindHit, 64'(i), 32'(i));
    send_item(KindEnd, '0, '0);
    // Hold the sender until every group of the full table is out.
    wait_drained();
    if (got.dropped_hits !== 16'd5) begin
      $error("dropped_hits exp %0d got %0d", 5, got.dropped_hits); errors++;
    end
    masks = '{'1, 64'hFFFF_FFFF_FFFF_FF00, 64'h0, 64'h8000_0000_0000_000F};
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      write_reg(CfgKeepMask, masks[ph]);
      write_reg(CfgRefBits, {$urandom, $urandom});
      for (int ev = 0; ev < 16; ev++) begin
        base = {$urandom, $urandom};
        ev_hits = $urandom_range(0, 8);
        pool = $urandom_range(1, 12);
        for (int h = 0; h < ev_hits; h++) begin
          if ($urandom_range(0, 7) == 0)
            send_item(KindHit, {$urandom, $urandom}, $urandom);
          else
            send_item(KindHit, base ^ 64'($urandom_range(0, pool)) ^
                      (64'($urandom_range(0, 3)) << 62),
                      ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4095));
        end
        send_item(KindEnd, {$urandom, $urandom}, $urandom);
      end
    end
    wait_drained();
    repeat (Depth * 4) @(posedge clk);
    if (errors == 0) $display("masked_key_energy_merger_core: match");
    else $display("masked_key_energy_merger_core: mismatch");
    $finish;
  end

  initial begin
    #20000000;
    $display("masked_key_energy_merger_core: mismatch");
    $finish;
  end
endmodule
